// File: rtl/bks_pkg.sv
// Package for the bounded key stack: field widths, operation and status codes,
// and parameter defaults. No dependencies; every other file imports it.
`default_nettype none

package bks_pkg;

	localparam int OP_W     = 3;
	localparam int KEY_W    = 64;
	localparam int POS_W    = 8;
	localparam int STATUS_W = 3;
	localparam int FPOS_W   = 5;

	localparam int DEPTH_DEF    = 16;
	localparam int KEY_BITS_DEF = 64;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH   = 3'd0,
		OP_POP    = 3'd1,
		OP_UPDATE = 3'd2,
		OP_VIEW   = 3'd3,
		OP_SEARCH = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_BADPOS   = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

endpackage

`default_nettype wire

// File: rtl/bks_if.sv
// Valid/ready channel interfaces for the bounded key stack: the command
// channel and the result channel. Depends on bks_pkg for field widths.
`default_nettype none

interface bks_cmd_if
	import bks_pkg::*;
	();
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  op;
	logic [KEY_W-1:0] key_value;
	logic [POS_W-1:0] position;

	modport source (output valid, output op, output key_value, output position, input ready);
	modport sink   (input valid, input op, input key_value, input position, output ready);
endinterface

interface bks_rsp_if
	import bks_pkg::*;
	();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [KEY_W-1:0]    data;
	logic [FPOS_W-1:0]   found_position;
	logic                last;

	modport source (output valid, output status, output data, output found_position,
		output last, input ready);
	modport sink   (input valid, input status, input data, input found_position,
		input last, output ready);
endinterface

`default_nettype wire

// File: rtl/bounded_key_stack_with_search.sv
// Bounded LIFO stack of keys with push, pop, positional update, view and search.
// Depends on bks_pkg and the channel interfaces in bks_if.sv.
//
// Usage: commands arrive as beats on the cmd channel (op, key_value,
// position) and results leave as beats on the rsp channel (status, data,
// found_position, last). Every command yields one result beat, except a view
// of a non-empty stack, which yields one beat per entry from the top down,
// with last set on the bottom entry.
// One command is taken at a time. Push, update, the empty cases and invalid
// opcodes load their result beat from the execute step. Pop, view and search
// first prime the registered read; search then compares the entries from
// the top down until a match or the bottom entry, and view presents one
// more entry per cycle while the receiver does not stall. The next command
// is taken in the cycle after the last result beat is loaded. The storage
// has one registered read port, and the walk reads one entry per cycle
// through it, holding while a view's result beat is stalled.
// cmd.ready is high only while the sequencer is idle. When the receiver
// stalls, the output register holds its beat and the sequencer waits before
// producing the next one. Reset empties the stack and drops any pending
// result; the stored keys themselves are not cleared.
`default_nettype none

module bounded_key_stack_with_search
	import bks_pkg::*;
	#(
	parameter int DEPTH    = DEPTH_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF
	) (
	input  wire       clk,
	input  wire       arst_n,
	bks_cmd_if.sink   cmd,
	bks_rsp_if.source rsp
	);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_PRIME,
		S_SCAN
	} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      count_q;
	logic [OP_W-1:0]       op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [POS_W-1:0]      pos_q;
	logic [IDX_W-1:0]      rd_idx_q;
	logic [CNT_W-1:0]      hit_pos_q;
	logic [KEY_BITS-1:0]   rd_data_q;
	logic [KEY_BITS-1:0]   entries_q [DEPTH];

	logic                  out_valid_q;
	logic [STATUS_W-1:0]   status_q;
	logic [KEY_W-1:0]      data_q;
	logic [FPOS_W-1:0]     found_q;
	logic                  last_q;

	logic                  out_free;
	logic                  is_empty;
	logic                  is_full;
	logic                  pos_ok;
	logic                  walk;
	logic                  at_end;
	logic                  match;
	logic                  adv;
	logic                  rd_en;
	logic                  wr_en;
	logic                  load_beat;
	logic [IDX_W-1:0]      wr_idx;
	status_t               exec_status;

	assign out_free = !out_valid_q || rsp.ready;
	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == CNT_W'(DEPTH));
	assign pos_ok   = (pos_q != '0) && (pos_q <= POS_W'(count_q));
	assign at_end   = (hit_pos_q == count_q);
	assign match    = (rd_data_q == key_q);

	always_comb begin
		walk        = 1'b0;
		wr_en       = 1'b0;
		wr_idx      = count_q[IDX_W-1:0];
		exec_status = ST_OK;
		case (op_q)
			OP_PUSH: begin
				if (is_full) begin
					exec_status = ST_FULL;
				end else begin
					wr_en = 1'b1;
				end
			end
			OP_UPDATE: begin
				wr_idx = IDX_W'(count_q - CNT_W'(pos_q));
				if (is_empty) begin
					exec_status = ST_EMPTY;
				end else if (!pos_ok) begin
					exec_status = ST_BADPOS;
				end else begin
					wr_en = 1'b1;
				end
			end
			OP_POP, OP_VIEW, OP_SEARCH: begin
				if (is_empty) begin
					exec_status = ST_EMPTY;
				end else begin
					walk = 1'b1;
				end
			end
			default: begin
				exec_status = ST_BADPOS;
			end
		endcase
		wr_en = wr_en && (state_q == S_EXEC) && out_free;
	end

	always_comb begin
		adv = 1'b0;
		if (state_q == S_SCAN) begin
			case (op_q)
				OP_VIEW:   adv = out_free && !at_end;
				OP_SEARCH: adv = !match && !at_end;
				default:   adv = 1'b0;
			endcase
		end
	end

	assign rd_en = (state_q == S_PRIME) || adv;

	assign load_beat = out_free && (((state_q == S_EXEC) && !walk) ||
		((state_q == S_SCAN) && ((op_q == OP_POP) || (op_q == OP_VIEW) || match || at_end)));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entries_q[wr_idx] <= key_q;
		end
		if (rd_en) begin
			rd_data_q <= entries_q[rd_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_beat) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						op_q    <= cmd.op;
						key_q   <= cmd.key_value[KEY_BITS-1:0];
						pos_q   <= cmd.position;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (out_free) begin
						if (walk) begin
							rd_idx_q  <= IDX_W'(count_q - 1'b1);
							hit_pos_q <= CNT_W'(1);
							state_q   <= S_PRIME;
							if (op_q == OP_POP) begin
								count_q <= count_q - 1'b1;
							end
						end else begin
							status_q    <= exec_status;
							data_q      <= '0;
							found_q     <= '0;
							last_q      <= 1'b1;
							state_q     <= S_IDLE;
							if (wr_en && op_q == OP_PUSH) begin
								count_q <= count_q + 1'b1;
							end
						end
					end
				end
				S_PRIME: begin
					rd_idx_q <= rd_idx_q - 1'b1;
					state_q  <= S_SCAN;
				end
				S_SCAN: begin
					if (adv) begin
						rd_idx_q  <= rd_idx_q - 1'b1;
						hit_pos_q <= hit_pos_q + 1'b1;
					end
					case (op_q)
						OP_POP, OP_VIEW: begin
							if (out_free) begin
								status_q    <= ST_OK;
								data_q      <= KEY_W'(rd_data_q);
								found_q     <= '0;
								last_q      <= (op_q == OP_POP) || at_end;
								if (op_q == OP_POP || at_end) begin
									state_q <= S_IDLE;
								end
							end
						end
						default: begin
							if ((match || at_end) && out_free) begin
								status_q    <= match ? ST_OK : ST_NOTFOUND;
								data_q      <= '0;
								found_q     <= match ? FPOS_W'(hit_pos_q) : '0;
								last_q      <= 1'b1;
								state_q     <= S_IDLE;
							end
						end
					endcase
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cmd.ready          = (state_q == S_IDLE);
	assign rsp.valid          = out_valid_q;
	assign rsp.status         = status_q;
	assign rsp.data           = data_q;
	assign rsp.found_position = found_q;
	assign rsp.last           = last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("Stack count exceeds its depth.");

	a_write_only_exec: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_EXEC) && out_free)
		else $error("Storage written outside the execute step.");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) && out_free && walk && (op_q == OP_POP)
		|=> count_q == $past(count_q) - 1'b1)
		else $error("Pop did not remove exactly one entry.");

	a_not_last_is_view: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !last_q |-> (op_q == OP_VIEW) && (state_q == S_SCAN))
		else $error("A non-final result beat outside a view walk.");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) && (op_q != OP_POP)
		|-> (hit_pos_q != '0) && (hit_pos_q <= count_q))
		else $error("Walk position left the filled part of the stack.");

endmodule

`default_nettype wire
